FILE: hw/rtl/i2c_eeprom_master_core_assert.svh
// assertion macros, clocked on clk, disabled while rst_n is low
`ifndef I2C_EEPROM_MASTER_CORE_ASSERT_SVH
`define I2C_EEPROM_MASTER_CORE_ASSERT_SVH

// same-cycle implication
`define I2CEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/i2cee_pkg.sv
package i2cee_pkg;

  localparam logic [7:0] DEV_BASE       = 8'hA0;
  localparam logic [7:0] DEV_CUR_READ   = 8'hA1;
  localparam logic [7:0] READ_BIT       = 8'h01;
  localparam logic [7:0] INTERVAL_RESET = 8'd50;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_CUR_READ = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEV_NACK = 2'd1;
  localparam logic [1:0] ST_DAT_NACK = 2'd2;

  typedef enum logic [6:0] {
    SEG_IDLE  = 7'b0000001,
    SEG_START = 7'b0000010,
    SEG_TXBIT = 7'b0000100,
    SEG_RXACK = 7'b0001000,
    SEG_RXBIT = 7'b0010000,
    SEG_TXACK = 7'b0100000,
    SEG_STOP  = 7'b1000000
  } seg_t;

  typedef enum logic [4:0] {
    STG_DEVW  = 5'b00001,
    STG_WADDR = 5'b00010,
    STG_WDATA = 5'b00100,
    STG_DEVR  = 5'b01000,
    STG_RDATA = 5'b10000
  } stage_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] mem_addr;
    logic [2:0]  byte_count;
    logic [31:0] write_data;
    logic        send_stop;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;
  } res_t;

  // actions per segment
  function automatic logic [2:0] seg_actions(seg_t seg);
    logic [2:0] n;
    case (seg)
      SEG_IDLE:  n = 3'd1;
      SEG_TXACK: n = 3'd4;
      SEG_STOP:  n = 3'd4;
      default:   n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] write_byte(logic [31:0] data, logic [2:0] k);
    logic [7:0] b;
    if (k[2]) begin
      b = 8'h00;
    end else begin
      b = data[{k[1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/i2c_eeprom_master_core.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tuser op, in_tdata command and sda sample
// out     | out | out_tvalid/tready  | out_tdata line levels, flags, status, read data
// cfg     | in  | cfg_we             | cfg_wdata interval_ticks
//
// one result per input transfer, computed combinationally and captured in the output register
// an input transfer is taken every cycle while the output register is free or draining
// the sequencer state steps only on an input transfer, never on idle cycles
// rst_n is synchronous: lines released, sequencer idle, interval_ticks back to 50
// a stalled output holds its result and blocks new input transfers
`include "i2c_eeprom_master_core_assert.svh"

module i2c_eeprom_master_core #(
  parameter int MAX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op
  input  logic [1:0]  in_tuser,
  // mem_addr, byte_count, write_data, send_stop, sda_in
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level, sda_level, busy_res, done_res, status, read_data
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic [7:0]       interval_ticks_r;
  logic             in_xfer;
  i2cee_pkg::item_t item;
  i2cee_pkg::res_t  res;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    item.op         = in_tuser;
    item.mem_addr   = in_tdata[10:0];
    item.byte_count = in_tdata[13:11];
    item.write_data = in_tdata[45:14];
    item.send_stop  = in_tdata[46];
    item.sda_in     = in_tdata[47];
  end

  i2cee_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_xfer),
    .item          (item),
    .interval_ticks(interval_ticks_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_ticks_r <= i2cee_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      interval_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {2'b00, res.read_data, res.status, res.done_res, res.busy_res,
                     res.sda_level, res.scl_level};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `I2CEE_ASSERT_NXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "no result after input")
  `I2CEE_ASSERT_IMP(a_done_not_busy, out_tvalid && out_tdata[3], !out_tdata[2], "done while busy")
  `I2CEE_ASSERT_IMP(a_data_with_done, out_tvalid && !out_tdata[3], out_tdata[37:6] == 32'h0, "read data without done")

endmodule

FILE: hw/rtl/i2cee_seq.sv
module i2cee_seq #(
  parameter int MAX_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cee_pkg::item_t item,
  input  logic [7:0]       interval_ticks,
  output i2cee_pkg::res_t  res
);

  i2cee_pkg::seg_t   seg_r, seg_nxt;
  i2cee_pkg::stage_t stage_r, stage_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [7:0]  icnt_r, icnt_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [31:0] data_r, data_nxt;
  logic [10:0] addr_r, addr_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  ops_r, ops_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        fin;
  logic        do_apply;
  logic [7:0]  lim;
  logic [8:0]  icnt_inc;
  logic        is_last;

  assign lim      = (interval_ticks == 8'd0) ? 8'd1 : interval_ticks;
  assign icnt_inc = {1'b0, icnt_r} + 9'd1;

  always_comb begin
    seg_nxt   = seg_r;
    stage_nxt = stage_r;
    sub_nxt   = sub_r;
    icnt_nxt  = icnt_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    data_nxt  = data_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    ops_nxt   = ops_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    stat_nxt  = stat_r;
    fin       = 1'b0;
    do_apply  = 1'b0;
    is_last   = 1'b0;

    if (seg_r == i2cee_pkg::SEG_IDLE) begin
      if (item.op != i2cee_pkg::OP_TICK) begin
        if (item.byte_count == 3'd0) begin
          cnt_nxt = 4'd1;
        end else if ({1'b0, item.byte_count} > 4'(MAX_BYTES)) begin
          cnt_nxt = 4'(MAX_BYTES);
        end else begin
          cnt_nxt = {1'b0, item.byte_count};
        end
        addr_nxt = item.mem_addr;
        ops_nxt  = {item.send_stop, item.op};
        data_nxt = (item.op == i2cee_pkg::OP_WRITE) ? item.write_data : 32'h0;
        stat_nxt = i2cee_pkg::ST_OK;
        byte_nxt = 3'd0;
        icnt_nxt = 8'd0;
        if (item.op == i2cee_pkg::OP_CUR_READ) begin
          stage_nxt = i2cee_pkg::STG_DEVR;
          shift_nxt = i2cee_pkg::DEV_CUR_READ;
        end else begin
          stage_nxt = i2cee_pkg::STG_DEVW;
          shift_nxt = i2cee_pkg::DEV_BASE | {4'h0, item.mem_addr[10:8], 1'b0};
        end
        seg_nxt  = i2cee_pkg::SEG_START;
        sub_nxt  = 2'd0;
        bit_nxt  = 3'd0;
        do_apply = 1'b1;
      end
    end else if (icnt_inc < {1'b0, lim}) begin
      icnt_nxt = icnt_inc[7:0];
    end else begin
      icnt_nxt = 8'd0;
      is_last  = ({1'b0, byte_r} + 4'd1) >= cnt_r;
      if (({1'b0, sub_r} + 3'd1) < i2cee_pkg::seg_actions(seg_r)) begin
        sub_nxt  = sub_r + 2'd1;
        do_apply = 1'b1;
      end else if ((seg_r == i2cee_pkg::SEG_TXBIT || seg_r == i2cee_pkg::SEG_RXBIT)
                   && bit_r != 3'd7) begin
        sub_nxt  = 2'd0;
        bit_nxt  = bit_r + 3'd1;
        do_apply = 1'b1;
      end else begin
        // segment end: default is entering a new segment
        sub_nxt  = 2'd0;
        bit_nxt  = 3'd0;
        do_apply = 1'b1;
        case (seg_r)
          i2cee_pkg::SEG_START: seg_nxt = i2cee_pkg::SEG_TXBIT;
          i2cee_pkg::SEG_TXBIT: seg_nxt = i2cee_pkg::SEG_RXACK;
          i2cee_pkg::SEG_RXACK: begin
            scl_nxt = 1'b0;
            if (item.sda_in) begin
              stat_nxt = (stage_r == i2cee_pkg::STG_DEVW || stage_r == i2cee_pkg::STG_DEVR)
                         ? i2cee_pkg::ST_DEV_NACK : i2cee_pkg::ST_DAT_NACK;
              seg_nxt  = i2cee_pkg::SEG_STOP;
            end else begin
              case (stage_r)
                i2cee_pkg::STG_DEVW: begin
                  stage_nxt = i2cee_pkg::STG_WADDR;
                  shift_nxt = addr_r[7:0];
                  seg_nxt   = i2cee_pkg::SEG_TXBIT;
                end
                i2cee_pkg::STG_WADDR: begin
                  if (ops_r[1:0] == i2cee_pkg::OP_WRITE) begin
                    stage_nxt = i2cee_pkg::STG_WDATA;
                    byte_nxt  = 3'd0;
                    shift_nxt = i2cee_pkg::write_byte(data_r, 3'd0);
                    seg_nxt   = i2cee_pkg::SEG_TXBIT;
                  end else begin
                    stage_nxt = i2cee_pkg::STG_DEVR;
                    shift_nxt = i2cee_pkg::DEV_BASE | {4'h0, addr_r[10:8], 1'b0}
                                | i2cee_pkg::READ_BIT;
                    seg_nxt   = i2cee_pkg::SEG_START;
                  end
                end
                i2cee_pkg::STG_WDATA: begin
                  if (is_last) begin
                    if (ops_r[2]) begin
                      seg_nxt = i2cee_pkg::SEG_STOP;
                    end else begin
                      seg_nxt  = i2cee_pkg::SEG_IDLE;
                      fin      = 1'b1;
                      do_apply = 1'b0;
                    end
                  end else begin
                    byte_nxt  = byte_r + 3'd1;
                    shift_nxt = i2cee_pkg::write_byte(data_r, byte_r + 3'd1);
                    seg_nxt   = i2cee_pkg::SEG_TXBIT;
                  end
                end
                default: begin
                  stage_nxt = i2cee_pkg::STG_RDATA;
                  byte_nxt  = 3'd0;
                  seg_nxt   = i2cee_pkg::SEG_RXBIT;
                end
              endcase
            end
          end
          i2cee_pkg::SEG_RXBIT: begin
            if (!byte_r[2]) begin
              data_nxt[{byte_r[1:0], 3'b000} +: 8] =
                data_r[{byte_r[1:0], 3'b000} +: 8] | shift_r;
            end
            seg_nxt = i2cee_pkg::SEG_TXACK;
          end
          i2cee_pkg::SEG_TXACK: begin
            if (is_last) begin
              if (ops_r[2]) begin
                seg_nxt = i2cee_pkg::SEG_STOP;
              end else begin
                seg_nxt  = i2cee_pkg::SEG_IDLE;
                fin      = 1'b1;
                do_apply = 1'b0;
              end
            end else begin
              byte_nxt = byte_r + 3'd1;
              seg_nxt  = i2cee_pkg::SEG_RXBIT;
            end
          end
          default: begin
            seg_nxt  = i2cee_pkg::SEG_IDLE;
            fin      = 1'b1;
            do_apply = 1'b0;
          end
        endcase
      end
    end

    // line action of the new phase
    if (do_apply) begin
      case (seg_nxt)
        i2cee_pkg::SEG_START: begin
          case (sub_nxt)
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b0;
          endcase
        end
        i2cee_pkg::SEG_TXBIT: begin
          case (sub_nxt)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = shift_nxt[3'd7 - bit_nxt];
            default: scl_nxt = 1'b1;
          endcase
        end
        i2cee_pkg::SEG_RXACK: begin
          case (sub_nxt)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b1;
            default: scl_nxt = 1'b1;
          endcase
        end
        i2cee_pkg::SEG_RXBIT: begin
          case (sub_nxt)
            2'd0: begin
              scl_nxt = 1'b0;
              sda_nxt = 1'b1;
            end
            2'd1:    scl_nxt = 1'b1;
            default: shift_nxt = {shift_nxt[6:0], item.sda_in};
          endcase
        end
        i2cee_pkg::SEG_TXACK: begin
          case (sub_nxt)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = ({1'b0, byte_nxt} + 4'd1) >= cnt_nxt;
            2'd2:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cee_pkg::SEG_STOP: begin
          case (sub_nxt)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (seg_nxt != i2cee_pkg::SEG_IDLE);
    res.done_res  = fin;
    res.status    = stat_nxt;
    res.read_data = (fin && ops_nxt[1:0] != i2cee_pkg::OP_WRITE) ? data_nxt : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= i2cee_pkg::SEG_IDLE;
      stage_r <= i2cee_pkg::STG_DEVW;
      sub_r   <= 2'd0;
      icnt_r  <= 8'd0;
      bit_r   <= 3'd0;
      byte_r  <= 3'd0;
      shift_r <= 8'd0;
      data_r  <= 32'h0;
      addr_r  <= 11'd0;
      cnt_r   <= 4'd0;
      ops_r   <= 3'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      stat_r  <= i2cee_pkg::ST_OK;
    end else if (step) begin
      seg_r   <= seg_nxt;
      stage_r <= stage_nxt;
      sub_r   <= sub_nxt;
      icnt_r  <= icnt_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      data_r  <= data_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      ops_r   <= ops_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule
